// ===== src/cvc_pkg.sv =====
// Shared types, register codes and defaults for the chunk visibility cull block.
package cvc_pkg;

	localparam int CHUNK_WIDTH_DEF = 16;
	localparam int CHUNK_TALL_DEF = 256;

	localparam int NUM_PLANES = 6;
	localparam int NORMAL_W = 12;
	localparam int OFFSET_W = 28;
	localparam int COORD_IN_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int RSQ_W = 13;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_CENTER = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_DISTANCE = 3'd7;

	// Reset view distance is 8 chunks, so the reset radius squared is 9 * 9.
	localparam logic [RSQ_W-1:0] RSQ_RESET = 13'd81;

	typedef struct packed {
		logic signed [OFFSET_W-1:0] d;
		logic signed [NORMAL_W-1:0] nz;
		logic signed [NORMAL_W-1:0] ny;
		logic signed [NORMAL_W-1:0] nx;
	} plane_t;

	typedef enum logic [1:0] {
		REASON_VISIBLE = 2'd0,
		REASON_DISTANCE = 2'd1,
		REASON_FRUSTUM = 2'd2
	} reason_t;

endpackage

// ===== src/chunk_visibility_cull_top.sv =====
// Top level of the chunk visibility cull block: distance test and six-plane frustum test.
//
//   Channel   Handshake                Payload
//   input     in_valid / in_ready      chunk_x, chunk_z
//   result    out_valid / out_ready    visible, cull_reason
//   config    cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Each chunk passes through the stage 1 to stage 4 registers between its input transfer and the
// cycle in which its result is shown, and a new chunk may be transferred in every cycle unless a
// stalled result has filled the four-stage pipeline, which has one slot per stage.
// Reset clears the stage valid bits and loads the register defaults: all planes zero, view
// center zero and view distance eight. The configuration port is always ready.
// A stage moves forward whenever the stage after it is empty or moving, so bubbles collapse
// and a stalled result does not stop the stages behind it from filling.
module chunk_visibility_cull_top #(
	parameter int CHUNK_WIDTH = cvc_pkg::CHUNK_WIDTH_DEF,
	parameter int CHUNK_TALL = cvc_pkg::CHUNK_TALL_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [cvc_pkg::COORD_IN_W-1:0]  chunk_x,
	input  logic signed [cvc_pkg::COORD_IN_W-1:0]  chunk_z,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic                                   visible,
	output logic [1:0]                             cull_reason,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [cvc_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [cvc_pkg::CFG_DATA_W-1:0]         cfg_data
);
	import cvc_pkg::*;

	// Box coordinates along x and z reach 32768 * CHUNK_WIDTH in magnitude, the y extent
	// reaches CHUNK_TALL; one signed width covers every axis.
	localparam int CW_BITS = $clog2(CHUNK_WIDTH + 1);
	localparam int XZ_W = COORD_IN_W + CW_BITS + 1;
	localparam int Y_W = $clog2(CHUNK_TALL + 1) + 1;
	localparam int AX_W = (XZ_W > Y_W) ? XZ_W : Y_W;
	localparam int PROD_W = NORMAL_W + AX_W;
	localparam int DOT_W = PROD_W + 3;
	localparam int DIFF_W = COORD_IN_W + 1;
	localparam int SQ_W = 2 * COORD_IN_W;
	localparam int SUMSQ_W = SQ_W + 1;
	localparam logic signed [AX_W-1:0] CW_S = AX_W'(CHUNK_WIDTH);
	localparam logic signed [AX_W-1:0] CT_S = AX_W'(CHUNK_TALL);

	// Configuration registers.
	plane_t                         planes_q [NUM_PLANES];
	logic signed [COORD_IN_W-1:0]   ctr_x_q;
	logic signed [COORD_IN_W-1:0]   ctr_z_q;
	logic [RSQ_W-1:0]               rsq_q;
	logic [6:0]                     radius;

	assign cfg_ready = 1'b1;
	assign radius = 7'(cfg_data[5:0]) + 7'd1;

	// The squared cull radius is formed once, when the view distance is written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				planes_q[i] <= '0;
			end
			ctr_x_q <= '0;
			ctr_z_q <= '0;
			rsq_q <= RSQ_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_VIEW_CENTER: begin
					ctr_x_q <= cfg_data[15:0];
					ctr_z_q <= cfg_data[31:16];
				end
				REG_VIEW_DISTANCE: begin
					rsq_q <= RSQ_W'(radius) * RSQ_W'(radius);
				end
				default: begin
					planes_q[cfg_index] <= cfg_data;
				end
			endcase
		end
	end

	// Stage enables: a stage loads when it is empty or its contents move on.
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4 = !v_s4 || out_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// Stage 1: offsets from the view center and the chunk box corners along x and z.
	logic signed [DIFF_W-1:0]  dx_s1, dz_s1;
	logic signed [AX_W-1:0]    x0_s1, x1_s1, z0_s1, z1_s1;
	logic signed [AX_W-1:0]    x0_c, z0_c;

	assign x0_c = AX_W'(chunk_x) * CW_S;
	assign z0_c = AX_W'(chunk_z) * CW_S;

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			dx_s1 <= DIFF_W'(chunk_x) - DIFF_W'(ctr_x_q);
			dz_s1 <= DIFF_W'(chunk_z) - DIFF_W'(ctr_z_q);
			x0_s1 <= x0_c;
			x1_s1 <= x0_c + CW_S;
			z0_s1 <= z0_c;
			z1_s1 <= z0_c + CW_S;
		end
	end

	// Stage 2: squared offsets and, for each plane, the products of the normal with the
	// positive vertex (box maximum on an axis whose normal component is not negative).
	logic [SQ_W-1:0]             sqx_s2, sqz_s2;
	logic signed [PROD_W-1:0]    px_s2 [NUM_PLANES];
	logic signed [PROD_W-1:0]    py_s2 [NUM_PLANES];
	logic signed [PROD_W-1:0]    pz_s2 [NUM_PLANES];
	logic signed [2*DIFF_W-1:0]  sqx_c, sqz_c;

	assign sqx_c = (2*DIFF_W)'(dx_s1) * (2*DIFF_W)'(dx_s1);
	assign sqz_c = (2*DIFF_W)'(dz_s1) * (2*DIFF_W)'(dz_s1);

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			sqx_s2 <= sqx_c[SQ_W-1:0];
			sqz_s2 <= sqz_c[SQ_W-1:0];
			for (int i = 0; i < NUM_PLANES; i++) begin
				px_s2[i] <= PROD_W'(planes_q[i].nx) *
					PROD_W'(planes_q[i].nx[NORMAL_W-1] ? x0_s1 : x1_s1);
				py_s2[i] <= PROD_W'(planes_q[i].ny) *
					PROD_W'(planes_q[i].ny[NORMAL_W-1] ? AX_W'(0) : CT_S);
				pz_s2[i] <= PROD_W'(planes_q[i].nz) *
					PROD_W'(planes_q[i].nz[NORMAL_W-1] ? z0_s1 : z1_s1);
			end
		end
	end

	// Stage 3: squared distance and one reject bit per plane (dot product plus offset < 0).
	logic [SUMSQ_W-1:0]        sumsq_s3;
	logic [NUM_PLANES-1:0]     reject_s3;
	logic signed [DOT_W-1:0]   dot_c [NUM_PLANES];

	always_comb begin
		for (int i = 0; i < NUM_PLANES; i++) begin
			dot_c[i] = DOT_W'(px_s2[i]) + DOT_W'(py_s2[i]) + DOT_W'(pz_s2[i]) +
				DOT_W'(planes_q[i].d);
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			sumsq_s3 <= SUMSQ_W'(sqx_s2) + SUMSQ_W'(sqz_s2);
			for (int i = 0; i < NUM_PLANES; i++) begin
				reject_s3[i] <= dot_c[i][DOT_W-1];
			end
		end
	end

	// Stage 4: the distance test wins over the frustum test; this stage is the result register.
	reason_t reason_s4;

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			if (sumsq_s3 > SUMSQ_W'(rsq_q)) begin
				reason_s4 <= REASON_DISTANCE;
			end else if (|reject_s3) begin
				reason_s4 <= REASON_FRUSTUM;
			end else begin
				reason_s4 <= REASON_VISIBLE;
			end
		end
	end

	assign out_valid = v_s4;
	assign cull_reason = reason_s4;
	assign visible = (reason_s4 == REASON_VISIBLE);

	// A full pipeline with a stalled result must refuse new chunks.
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && v_s4 && !out_ready) |-> !in_ready)
		else $error("input taken while the pipeline is full and stalled");

	// Every accepted chunk occupies the first stage in the next cycle.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted chunk did not enter the first stage");

	// A result advances whenever the downstream stage has room.
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && en4) |=> v_s4)
		else $error("result dropped between the last two stages");

	// The visible flag and the reason code always agree.
	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (visible == (cull_reason == REASON_VISIBLE)))
		else $error("visible flag disagrees with cull reason");

endmodule
